// ----- src/fam_pkg.sv -----
// Package for the binary32 add / multiply unit: field widths, constants and operation codes.
// Depends on nothing; used by the datapath module, the top level and the testbench.
`default_nettype none
package fam_pkg;
   localparam int unsigned FracBits = 23;
   localparam int unsigned ExpBits  = 8;
   localparam int unsigned SigBits  = 24;
   localparam logic [9:0]  ExpBias  = 10'd127;
   localparam logic [9:0]  ExpMax   = 10'd254;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_MUL = 1'b1
   } op_type;

   typedef struct packed {
      logic [31:0] word;
      logic        range_error;
   } result_type;
endpackage
`default_nettype wire

// ----- src/fam_datapath.sv -----
// Combinational datapath of the binary32 add / multiply unit with truncation.
// Depends on fam_pkg.
`default_nettype none
module fam_datapath (
   input  wire  fam_pkg::op_type     op,
   input  wire  [31:0]               a,
   input  wire  [31:0]               b,
   output fam_pkg::result_type       res
);
   logic              sa, sb;
   logic [7:0]        ea, eb;
   logic [23:0]       ma, mb;
   logic [7:0]        ediff;
   logic [7:0]        shift_amt;
   logic [23:0]       small_sh, big_m;
   logic [7:0]        big_e;
   logic              big_s, small_s;
   logic [24:0]       sum;
   logic [4:0]        lz;
   logic [24:0]       norm;
   logic signed [10:0] add_e;
   logic [47:0]       prod;
   logic signed [10:0] mul_e;
   logic [22:0]       mul_f;
   logic signed [10:0] fin_e;
   logic [22:0]       fin_f;
   logic              fin_s;
   logic              cancel;

   always_comb begin
      sa = a[31];
      sb = b[31];
      ea = a[30:23];
      eb = b[30:23];
      ma = {1'b1, a[22:0]};
      mb = {1'b1, b[22:0]};
      ediff = ea - eb;
      // Larger exponent keeps its significand; ties count as the right side.
      if (ea > eb) begin
         big_e = ea; big_m = ma; big_s = sa; small_s = sb;
         shift_amt = ediff;
         small_sh = (shift_amt >= 8'd24) ? 24'd0 : (mb >> shift_amt[4:0]);
      end else begin
         big_e = eb; big_m = mb; big_s = sb; small_s = sa;
         shift_amt = 8'd0 - ediff;
         small_sh = (shift_amt >= 8'd24) ? 24'd0 : (ma >> shift_amt[4:0]);
      end
      cancel = 1'b0;
      fin_s  = big_s;
      if (big_s == small_s) begin
         sum = {1'b0, big_m} + {1'b0, small_sh};
      end else if (big_m == small_sh) begin
         sum = 25'd0;
         cancel = 1'b1;
      end else if (big_m > small_sh) begin
         sum = {1'b0, big_m} - {1'b0, small_sh};
      end else begin
         sum = {1'b0, small_sh} - {1'b0, big_m};
         fin_s = small_s;
      end
      // Leading-one search over the 24 low bits of the sum.
      lz = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (sum[i]) lz = 5'(23 - i);
      end
      if (sum[24]) begin
         norm  = sum >> 1;
         add_e = 11'(big_e) + 11'sd1;
      end else begin
         norm  = sum << lz;
         add_e = 11'(big_e) - 11'(lz);
      end

      prod = 48'(ma) * 48'(mb);
      mul_e = 11'(ea) + 11'(eb) - 11'(fam_pkg::ExpBias);
      if (prod[47]) begin
         mul_f = prod[46:24];
         mul_e = mul_e + 11'sd1;
      end else begin
         mul_f = prod[45:23];
      end

      if (op == fam_pkg::OP_MUL) begin
         fin_e = mul_e; fin_f = mul_f; fin_s = sa ^ sb;
      end else begin
         fin_e = add_e; fin_f = norm[22:0];
      end

      if (op == fam_pkg::OP_ADD && cancel) begin
         res.word = 32'd0; res.range_error = 1'b0;
      end else if (fin_e > $signed(11'(fam_pkg::ExpMax))) begin
         res.word = {fin_s, 8'hFF, 23'd0}; res.range_error = 1'b1;
      end else if (fin_e < 11'sd1) begin
         res.word = {fin_s, 31'd0}; res.range_error = 1'b1;
      end else begin
         res.word = {fin_s, fin_e[7:0], fin_f}; res.range_error = 1'b0;
      end
   end
endmodule
`default_nettype wire

// ----- src/float32_add_multiply_truncating_unit.sv -----
// Top level of the binary32 add / multiply unit: input register, datapath, result register.
// Depends on fam_pkg and fam_datapath.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, kind, left/right_word  | in
//   rsp     | rsp_valid/ready, result_word, range_err | out
//
// A beat is taken whenever req_ready is high; it passes the input register and
// then the result register, from which its result is offered, and the pipeline
// sustains one beat per cycle while rsp is not stalled.
// Reset empties both stages. When rsp is stalled a stage advances only into a
// free slot, so ready falls only when both stages hold beats.
`default_nettype none
module float32_add_multiply_truncating_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_kind,
   input  wire  [31:0] req_left_word,
   input  wire  [31:0] req_right_word,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_result_word,
   output logic        rsp_range_error
);
   logic                 in_v_ff;
   fam_pkg::op_type      op_ff;
   logic [31:0]          a_ff, b_ff;
   logic                 out_v_ff;
   fam_pkg::result_type  res_ff, res_in;
   logic                 out_take, in_take;

   fam_datapath u_dp (.op(op_ff), .a(a_ff), .b(b_ff), .res(res_in));

   // The result stage frees up when empty or when its beat leaves this cycle.
   assign out_take  = !out_v_ff || rsp_ready;
   assign req_ready = !in_v_ff || out_take;
   assign in_take   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_ready) in_v_ff <= req_valid;
         if (out_take) out_v_ff <= in_v_ff;
      end
      if (in_take) begin
         op_ff <= fam_pkg::op_type'(req_kind);
         a_ff  <= req_left_word;
         b_ff  <= req_right_word;
      end
      if (out_take && in_v_ff) res_ff <= res_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_result_word = res_ff.word;
   assign rsp_range_error = res_ff.range_error;
endmodule
`default_nettype wire

// ----- bench/float32_add_multiply_truncating_unit_tb.sv -----
// Testbench for the binary32 add / multiply unit: random and directed beats
// checked against a predictor held in a small scoreboard class.
// Depends on fam_pkg and float32_add_multiply_truncating_unit.
`timescale 1ns / 100ps
`default_nettype none
module float32_add_multiply_truncating_unit_tb;

   // Expected result of one beat.
   typedef struct {
      logic [31:0] word;
      logic        range_error;
   } fp_result_type;

   // Packs sign, exponent and significand, saturating to infinity or zero
   // when the exponent leaves 1..254.
   function automatic fp_result_type fp_pack(logic sign, int e, logic [23:0] sig);
      fp_result_type r;
      if (e > int'(fam_pkg::ExpMax)) begin
         r.word = {sign, 8'hFF, 23'd0};
         r.range_error = 1'b1;
      end else if (e < 1) begin
         r.word = {sign, 31'd0};
         r.range_error = 1'b1;
      end else begin
         r.word = {sign, e[7:0], sig[22:0]};
         r.range_error = 1'b0;
      end
      return r;
   endfunction

   // Truncating binary32 sum; every encoding has an implied leading one.
   function automatic fp_result_type fp_sum(logic [31:0] a, logic [31:0] b);
      int unsigned ea, eb, d;
      int e;
      logic [24:0] ma, mb, m;
      logic sign;
      fp_result_type r;
      ea = 32'(a[30:23]);
      eb = 32'(b[30:23]);
      ma = {2'b01, a[22:0]};
      mb = {2'b01, b[22:0]};
      if (ea > eb) begin
         d = ea - eb;
         mb = (d >= 24) ? 25'd0 : mb >> d;
         e = int'(ea);
      end else begin
         d = eb - ea;
         ma = (d >= 24) ? 25'd0 : ma >> d;
         e = int'(eb);
      end
      if (a[31] == b[31]) begin
         m = ma + mb;
         sign = a[31];
      end else if (ma == mb) begin
         r.word = 32'd0;
         r.range_error = 1'b0;
         return r;
      end else if (ma > mb) begin
         m = ma - mb;
         sign = a[31];
      end else begin
         m = mb - ma;
         sign = b[31];
      end
      if (m[24]) begin
         m = m >> 1;
         e++;
      end
      while (!m[23]) begin
         m = m << 1;
         e--;
      end
      return fp_pack(sign, e, m[23:0]);
   endfunction

   // Truncating binary32 product.
   function automatic fp_result_type fp_product(logic [31:0] a, logic [31:0] b);
      logic [47:0] p;
      int e;
      p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
      e = int'(a[30:23]) + int'(b[30:23]) - int'(fam_pkg::ExpBias);
      if (p[47]) begin
         e++;
         return fp_pack(a[31] ^ b[31], e, p[47:24]);
      end
      return fp_pack(a[31] ^ b[31], e, p[46:23]);
   endfunction

   // Holds the results still owed by the block and checks each one that arrives.
   class fp_scoreboard;
      fp_result_type owed[$];
      int errors;

      function void note_beat(fam_pkg::op_type op, logic [31:0] a, logic [31:0] b);
         owed.push_back(op == fam_pkg::OP_MUL ? fp_product(a, b) : fp_sum(a, b));
      endfunction

      function void check_result(logic [31:0] word, logic range_error);
         fp_result_type x;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result %h/%b", $realtime, word, range_error);
            errors++;
            return;
         end
         x = owed.pop_front();
         if (x.word !== word) begin
            $display("%0t: result_word expected %h actual %h", $realtime, x.word, word);
            errors++;
         end
         if (x.range_error !== range_error) begin
            $display("%0t: range_error expected %b actual %b", $realtime,
                     x.range_error, range_error);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [31:0] req_left_word = 32'd0;
   logic [31:0] req_right_word = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_word;
   logic        rsp_range_error;

   fp_scoreboard results = new();
   bit   hold_off_request = 1'b0;   // asks the receiver for one long stall
   bit   hold_off_done = 1'b0;

   float32_add_multiply_truncating_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_left_word(req_left_word), .req_right_word(req_right_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_word(rsp_result_word), .rsp_range_error(rsp_range_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sampling happens at the rising edge: accepted inputs go into the
   // predictor, accepted results are checked right away.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            results.note_beat(fam_pkg::op_type'(req_kind), req_left_word, req_right_word);
         if (rsp_valid && rsp_ready)
            results.check_result(rsp_result_word, rsp_range_error);
      end
   end

   // Offers one beat and holds it, unchanged, until the block takes it.
   task automatic send_beat(fam_pkg::op_type op, logic [31:0] a, logic [31:0] b);
      req_valid <= 1'b1;
      req_kind <= op;
      req_left_word <= a;
      req_right_word <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drops valid for a random gap; a zero gap keeps valid high for back to
   // back beats so valid is never lowered and raised in one step.
   task automatic idle_gap(int unsigned cycles);
      if (cycles == 0) return;
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Random operand: a quarter with ordinary exponents, a quarter near the edges of
   // the range, and the rest with arbitrary bit patterns.
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 3))
         0: w[30:23] = 8'($urandom_range(100, 154));
         1: w[30:23] = $urandom_range(0, 3) == 0 ? 8'd0 :
                       8'd255 - 8'($urandom_range(0, 3));
         default: ;
      endcase
      return w;
   endfunction

   // Receiver: stalls on a pattern of its own, with quiet stretches, and
   // once holds off for a long stretch so the pipeline fills and stalls.
   initial begin
      int unsigned phase;
      phase = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (40) @(negedge clock);
            hold_off_done = 1'b1;
         end
         phase++;
         if ((phase / 200) % 3 == 2)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
         @(negedge clock);
      end
   end

   initial begin
      logic [31:0] a, b;
      int unsigned burst;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, both operations and each special case.
      send_beat(fam_pkg::OP_ADD, 32'h3F800000, 32'h3F800000);   // 1 + 1
      send_beat(fam_pkg::OP_ADD, 32'h3F800000, 32'hBF800000);   // exact cancellation
      send_beat(fam_pkg::OP_ADD, 32'h40000000, 32'hBFFFFFFF);   // deep renormalization
      send_beat(fam_pkg::OP_ADD, 32'h7F7FFFFF, 32'h7F7FFFFF);   // overflow to infinity
      send_beat(fam_pkg::OP_ADD, 32'hFF7FFFFF, 32'hFF000000);   // negative overflow
      send_beat(fam_pkg::OP_ADD, 32'h00800000, 32'h80FFFFFF);   // underflow to zero
      send_beat(fam_pkg::OP_ADD, 32'h4B800000, 32'h3F800000);   // alignment by 24
      send_beat(fam_pkg::OP_ADD, 32'h3F800000, 32'h4B7FFFFF);   // alignment by 23
      send_beat(fam_pkg::OP_ADD, 32'h00000000, 32'h00000000);   // zero decoded as normal
      send_beat(fam_pkg::OP_ADD, 32'h7F800000, 32'hFFFFFFFF);   // infinity / NaN codes
      send_beat(fam_pkg::OP_ADD, 32'hFFFFFFFF, 32'h00000000);
      send_beat(fam_pkg::OP_ADD, 32'hC0000000, 32'h3FFFFFFF);   // sign from the larger
      send_beat(fam_pkg::OP_MUL, 32'h3F800000, 32'h3F800000);
      send_beat(fam_pkg::OP_MUL, 32'h3FFFFFFF, 32'hBFFFFFFF);   // product carries out
      send_beat(fam_pkg::OP_MUL, 32'h7F000000, 32'h40000000);   // overflow
      send_beat(fam_pkg::OP_MUL, 32'h00800000, 32'h00800000);   // underflow
      send_beat(fam_pkg::OP_MUL, 32'h00000000, 32'hFFFFFFFF);
      send_beat(fam_pkg::OP_MUL, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_beat(fam_pkg::OP_MUL, 32'h3F800000, 32'h00800000);   // exponent lands on 1
      send_beat(fam_pkg::OP_MUL, 32'h3F800000, 32'h7F7FFFFF);   // exponent lands on 254

      // Pause until every result has come back.
      idle_gap(1);
      while (results.owed.size() != 0) @(negedge clock);

      // Random beats in bursts; one burst runs during the long receiver stall.
      for (int n = 0; n < 2000; ) begin
         burst = $urandom_range(1, 30);
         if (n > 600 && !hold_off_request) begin
            hold_off_request = 1'b1;
            burst = 60;
         end
         repeat (burst) begin
            a = random_word();
            b = random_word();
            if ($urandom_range(0, 5) == 0) b[30:23] = a[30:23];
            if ($urandom_range(0, 9) == 0) b = {~a[31], a[30:0]};
            send_beat(fam_pkg::op_type'($urandom_range(0, 1)), a, b);
            n++;
         end
         idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
      end
      idle_gap(1);

      while (results.owed.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (results.errors == 0 && results.owed.size() == 0)
         $display("float32_add_multiply_truncating_unit verification clean");
      else
         $display("float32_add_multiply_truncating_unit verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("float32_add_multiply_truncating_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire
